// File: rtl/itc_pkg.sv
// Shared constants, tables and latency figures for the internal-to-Cartesian point placer.
package itc_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int FRAC_BITS_DEF = 16;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 24;
	localparam int TORSION_W = 26;
	localparam int LENGTH_W = 24;
	localparam int DEG_W = 27;
	localparam int CORDIC_W = 34;
	localparam int VEC_W = 31;
	localparam int OFF_W = 27;
	localparam int SUM_W = 34;

	localparam logic signed [27:0] DEG360 = 28'sd23592960;
	localparam logic signed [27:0] DEG180 = 28'sd11796480;
	localparam logic signed [27:0] DEG90 = 28'sd5898240;
	localparam logic signed [27:0] DEG2RAD_Q32 = 28'sd74961321;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

	localparam int OFFSET_LAT = 4;
	localparam int FINAL_LAT = 3;

	function automatic int sincos_lat(input int steps);
		return steps + 5;
	endfunction

	function automatic int unit_lat(input int frac);
		return frac + 37;
	endfunction

	function automatic int frame_lat(input int frac);
		return unit_lat(frac) + 11;
	endfunction

	function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [CORDIC_W-1:0] r;
		case (i)
			5'd0: r = 34'sh03243F6A8;
			5'd1: r = 34'sh01DAC6705;
			5'd2: r = 34'sh00FADBAFC;
			5'd3: r = 34'sh007F56EA6;
			5'd4: r = 34'sh003FEAB76;
			5'd5: r = 34'sh001FFD55B;
			5'd6: r = 34'sh000FFFAAA;
			5'd7: r = 34'sh0007FFF55;
			5'd8: r = 34'sh0003FFFEA;
			5'd9: r = 34'sh0001FFFFD;
			5'd10: r = 34'sh0000FFFFF;
			5'd11: r = 34'sh00007FFFF;
			5'd12: r = 34'sh00003FFFF;
			5'd13: r = 34'sh00001FFFF;
			5'd14: r = 34'sh00000FFFF;
			5'd15: r = 34'sh000007FFF;
			5'd16: r = 34'sh000003FFF;
			5'd17: r = 34'sh000001FFF;
			5'd18: r = 34'sh000000FFF;
			5'd19: r = 34'sh0000007FF;
			5'd20: r = 34'sh0000003FF;
			5'd21: r = 34'sh0000001FF;
			5'd22: r = 34'sh0000000FF;
			5'd23: r = 34'sh00000007F;
			5'd24: r = 34'sh00000003F;
			5'd25: r = 34'sh00000001F;
			5'd26: r = 34'sh00000000F;
			5'd27: r = 34'sh000000007;
			5'd28: r = 34'sh000000003;
			5'd29: r = 34'sh000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/internal_to_cartesian_point.sv
// Top level of the pipelined internal-to-Cartesian point placer.
//
//   channel   handshake        payload
//   input     start / busy     a_*, b_*, c_*, bond_angle, torsion, bond_length
//   result    done             d_x, d_y, d_z, degenerate
//
// One transaction is accepted every cycle; busy is always low.
// The latency is set by the square root (31 stages) and the restoring divider
// (FRAC_BITS + 1 stages) of the unit-vector pipelines. The CORDIC branch runs
// alongside and is delay-matched. Reset clears only done and the itc_delay lines
// (the valid bits among them); the receiver cannot stall, so nothing holds.
module internal_to_cartesian_point #(
	parameter int CORDIC_STEPS = itc_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS = itc_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] c_x,
	input  logic signed [31:0] c_y,
	input  logic signed [31:0] c_z,
	input  logic [23:0]        bond_angle,
	input  logic signed [25:0] torsion,
	input  logic [23:0]        bond_length,
	output logic               done,
	output logic signed [31:0] d_x,
	output logic signed [31:0] d_y,
	output logic signed [31:0] d_z,
	output logic               degenerate
);

	localparam int SCW = FRAC_BITS + 3;
	localparam int UW = FRAC_BITS + 3;
	localparam int OW = itc_pkg::OFF_W;
	localparam int SW = itc_pkg::SUM_W;
	localparam int PW = 25 + SCW;
	localparam int QW = OW + SCW;
	localparam int MW = UW + OW;
	localparam int LS = itc_pkg::sincos_lat(CORDIC_STEPS);
	localparam int LF = itc_pkg::frame_lat(FRAC_BITS);
	localparam int OFS_DLY = LF - LS - itc_pkg::OFFSET_LAT;
	localparam int TOTAL_LAT = LF + itc_pkg::FINAL_LAT;
	localparam logic signed [PW-1:0] RND_P = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QW-1:0] RND_Q = QW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [MW+1:0] RND_M = (MW+2)'(1) <<< (FRAC_BITS - 1);

	logic                accept;
	logic                val_w;
	logic signed [31:0]  av [3];
	logic signed [31:0]  bv [3];
	logic signed [31:0]  cv [3];
	logic signed [SCW-1:0] sa, ca, st, ct;
	logic [23:0]         r_d;
	logic signed [PW-1:0] prs_o1, pz_o1;
	logic signed [SCW-1:0] st_o1, ct_o1, st_o2, ct_o2;
	logic signed [OW-1:0] rs_o2, zp_o2, zp_o3, xp_o4, yp_o4, zp_o4;
	logic signed [QW-1:0] px_o3, py_o3;
	logic [3*OW-1:0]     ofs_pk, ofs_d;
	logic signed [OW-1:0] xp, yp, zp;
	logic [95:0]         c_pk, c_pk_d;
	logic signed [UW-1:0] ux [3];
	logic signed [UW-1:0] uy [3];
	logic signed [UW-1:0] uz [3];
	logic                deg_f;
	logic signed [MW-1:0] pm_m1 [3][3];
	logic signed [31:0]  c_m1 [3];
	logic signed [31:0]  c_m2 [3];
	logic                deg_m1, deg_m2;
	logic signed [SW-1:0] acc_m2 [3];
	logic signed [MW+1:0] acc_w [3];
	logic signed [SW:0]  fin_w [3];
	logic signed [31:0]  sat_w [3];

	assign busy = 1'b0;
	assign accept = start && !busy;

	assign av = '{a_x, a_y, a_z};
	assign bv = '{b_x, b_y, b_z};
	assign cv = '{c_x, c_y, c_z};

	itc_sincos #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_sc_ang (
		.clk(clk), .ang(signed'({3'b000, bond_angle})), .sin_v(sa), .cos_v(ca)
	);

	itc_sincos #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_sc_tor (
		.clk(clk), .ang(itc_pkg::DEG_W'(torsion)), .sin_v(st), .cos_v(ct)
	);

	itc_delay #(.WIDTH(24), .DEPTH(LS)) u_len (
		.clk(clk), .arst_n(arst_n), .din(bond_length), .dout(r_d)
	);

	always_ff @(posedge clk) begin
		prs_o1 <= signed'({1'b0, r_d}) * sa;
		pz_o1 <= signed'({1'b0, r_d}) * ca;
		st_o1 <= st;
		ct_o1 <= ct;
		rs_o2 <= OW'((prs_o1 + RND_P) >>> FRAC_BITS);
		zp_o2 <= OW'((pz_o1 + RND_P) >>> FRAC_BITS);
		st_o2 <= st_o1;
		ct_o2 <= ct_o1;
		px_o3 <= rs_o2 * ct_o2;
		py_o3 <= rs_o2 * st_o2;
		zp_o3 <= zp_o2;
		xp_o4 <= OW'((px_o3 + RND_Q) >>> FRAC_BITS);
		yp_o4 <= OW'((py_o3 + RND_Q) >>> FRAC_BITS);
		zp_o4 <= zp_o3;
	end

	assign ofs_pk = {xp_o4, yp_o4, zp_o4};

	itc_delay #(.WIDTH(3*OW), .DEPTH(OFS_DLY)) u_ofs (
		.clk(clk), .arst_n(arst_n), .din(ofs_pk), .dout(ofs_d)
	);

	assign xp = signed'(ofs_d[3*OW-1:2*OW]);
	assign yp = signed'(ofs_d[2*OW-1:OW]);
	assign zp = signed'(ofs_d[OW-1:0]);

	itc_frame #(.FRAC(FRAC_BITS)) u_frame (
		.clk(clk), .arst_n(arst_n), .a(av), .b(bv), .c(cv),
		.ux(ux), .uy(uy), .uz(uz), .degenerate(deg_f)
	);

	assign c_pk = {c_x, c_y, c_z};

	itc_delay #(.WIDTH(96), .DEPTH(LF)) u_cdly (
		.clk(clk), .arst_n(arst_n), .din(c_pk), .dout(c_pk_d)
	);

	itc_delay #(.WIDTH(1), .DEPTH(LF+2)) u_valid (
		.clk(clk), .arst_n(arst_n), .din(accept), .dout(val_w)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pm_m1[i][0] <= ux[i] * xp;
			pm_m1[i][1] <= uy[i] * yp;
			pm_m1[i][2] <= uz[i] * zp;
		end
		c_m1[0] <= signed'(c_pk_d[95:64]);
		c_m1[1] <= signed'(c_pk_d[63:32]);
		c_m1[2] <= signed'(c_pk_d[31:0]);
		deg_m1 <= deg_f;
		for (int i = 0; i < 3; i++) acc_m2[i] <= SW'((acc_w[i] + RND_M) >>> FRAC_BITS);
		c_m2 <= c_m1;
		deg_m2 <= deg_m1;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_w[i] = (MW+2)'(pm_m1[i][0]) + (MW+2)'(pm_m1[i][1]) + (MW+2)'(pm_m1[i][2]);
			fin_w[i] = (SW+1)'(acc_m2[i]) + (SW+1)'(c_m2[i]);
			if (fin_w[i] > (SW+1)'(32'sh7FFFFFFF)) sat_w[i] = 32'sh7FFFFFFF;
			else if (fin_w[i] < -(SW+1)'(33'sh080000000)) sat_w[i] = 32'sh80000000;
			else sat_w[i] = 32'(fin_w[i]);
		end
	end

	always_ff @(posedge clk) begin
		d_x <= deg_m2 ? c_m2[0] : sat_w[0];
		d_y <= deg_m2 ? c_m2[1] : sat_w[1];
		d_z <= deg_m2 ? c_m2[2] : sat_w[2];
		degenerate <= deg_m2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= val_w;
		end
	end

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##TOTAL_LAT done)
		else $error("accepted transaction did not complete after the pipeline latency");

	a_degen_c: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> d_x == $past(c_m2[0]) && d_y == $past(c_m2[1])
			&& d_z == $past(c_m2[2]))
		else $error("degenerate result does not equal the anchor point");
`endif

endmodule

// File: rtl/itc_delay.sv
// Fixed-length register delay line used to align operands between pipeline branches.
module itc_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) tap_q[k] <= '0;
		end else begin
			tap_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) tap_q[k] <= tap_q[k-1];
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

// File: rtl/itc_sincos.sv
// Pipelined angle reduction, degree-to-radian scaling and rotation-mode CORDIC.
module itc_sincos #(
	parameter int STEPS = itc_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC = itc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic signed [itc_pkg::DEG_W-1:0]  ang,
	output logic signed [FRAC+2:0]            sin_v,
	output logic signed [FRAC+2:0]            cos_v
);

	localparam int CW = itc_pkg::CORDIC_W;
	localparam int SCW = FRAC + 3;
	localparam logic signed [CW-1:0] RND_C = CW'(1) <<< (29 - FRAC);

	logic signed [27:0] t_a, t_b, t_c, t_d, t_e;
	logic               neg_c;
	logic signed [27:0] t_s1;
	logic signed [23:0] t_s2;
	logic               neg_s2, neg_s3, neg_s4;
	logic signed [51:0] prod_s3;
	logic signed [CW-1:0] cx_s [STEPS+1];
	logic signed [CW-1:0] cy_s [STEPS+1];
	logic signed [CW-1:0] cz_s [STEPS+1];
	logic                 cn_s [STEPS+1];
	logic signed [CW-1:0] xr, yr;

	always_comb begin
		t_a = 28'(ang);
		if (t_a >= itc_pkg::DEG360) t_b = t_a - itc_pkg::DEG360;
		else if (t_a <= -itc_pkg::DEG360) t_b = t_a + itc_pkg::DEG360;
		else t_b = t_a;
		t_c = (t_b < 0) ? t_b + itc_pkg::DEG360 : t_b;
	end

	always_comb begin
		t_d = (t_s1 > itc_pkg::DEG180) ? t_s1 - itc_pkg::DEG360 : t_s1;
		neg_c = 1'b0;
		if (t_d > itc_pkg::DEG90) begin
			t_e = t_d - itc_pkg::DEG180;
			neg_c = 1'b1;
		end else if (t_d < -itc_pkg::DEG90) begin
			t_e = t_d + itc_pkg::DEG180;
			neg_c = 1'b1;
		end else begin
			t_e = t_d;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_c;
		t_s2 <= 24'(t_e);
		neg_s2 <= neg_c;
		prod_s3 <= t_s2 * itc_pkg::DEG2RAD_Q32;
		neg_s3 <= neg_s2;
		cz_s[0] <= CW'((prod_s3 + 52'sd131072) >>> 18);
		cx_s[0] <= itc_pkg::CORDIC_GAIN;
		cy_s[0] <= '0;
		cn_s[0] <= neg_s3;
	end

	assign neg_s4 = cn_s[0];

	for (genvar g = 0; g < STEPS; g++) begin : g_iter
		always_ff @(posedge clk) begin
			if (cz_s[g] >= 0) begin
				cx_s[g+1] <= cx_s[g] - (cy_s[g] >>> g);
				cy_s[g+1] <= cy_s[g] + (cx_s[g] >>> g);
				cz_s[g+1] <= cz_s[g] - itc_pkg::atan_q30(5'(g));
			end else begin
				cx_s[g+1] <= cx_s[g] + (cy_s[g] >>> g);
				cy_s[g+1] <= cy_s[g] - (cx_s[g] >>> g);
				cz_s[g+1] <= cz_s[g] + itc_pkg::atan_q30(5'(g));
			end
			cn_s[g+1] <= (g == 0) ? neg_s4 : cn_s[g];
		end
	end

	assign xr = (cx_s[STEPS] + RND_C) >>> (30 - FRAC);
	assign yr = (cy_s[STEPS] + RND_C) >>> (30 - FRAC);

	always_ff @(posedge clk) begin
		cos_v <= cn_s[STEPS] ? -SCW'(xr) : SCW'(xr);
		sin_v <= cn_s[STEPS] ? -SCW'(yr) : SCW'(yr);
	end

endmodule

// File: rtl/itc_bscale.sv
// Three-stage block scaling of a three-component vector to a largest magnitude in [2^29, 2^30).
module itc_bscale #(
	parameter int IN_W = 33
) (
	input  logic                              clk,
	input  logic signed [IN_W-1:0]            v [3],
	output logic signed [itc_pkg::VEC_W-1:0]  o [3],
	output logic                              zero
);

	logic [IN_W-1:0]        ab [3];
	logic [IN_W-1:0]        mx;
	logic signed [IN_W-1:0] v_s1 [3];
	logic signed [IN_W-1:0] v_s2 [3];
	logic [IN_W-1:0]        m_s1;
	logic [7:0]             bl;
	logic signed [7:0]      sh_s2;
	logic                   zero_s2;
	logic [5:0]             amt;

	always_comb begin
		for (int i = 0; i < 3; i++) ab[i] = v[i][IN_W-1] ? IN_W'(-v[i]) : IN_W'(v[i]);
		mx = ab[0];
		if (ab[1] > mx) mx = ab[1];
		if (ab[2] > mx) mx = ab[2];
	end

	always_comb begin
		bl = '0;
		for (int k = 0; k < IN_W; k++) if (m_s1[k]) bl = 8'(k + 1);
	end

	assign amt = sh_s2[7] ? 6'(-sh_s2) : 6'(sh_s2);

	always_ff @(posedge clk) begin
		v_s1 <= v;
		m_s1 <= mx;
		v_s2 <= v_s1;
		sh_s2 <= signed'(bl) - 8'sd30;
		zero_s2 <= (m_s1 == '0);
		for (int i = 0; i < 3; i++) begin
			if (sh_s2 > 0) o[i] <= itc_pkg::VEC_W'(v_s2[i] >>> amt);
			else o[i] <= itc_pkg::VEC_W'(v_s2[i] <<< amt);
		end
		zero <= zero_s2;
	end

endmodule

// File: rtl/itc_unit3.sv
// Unit vector pipeline: sum of squares, digit-by-digit square root and restoring division.
module itc_unit3 #(
	parameter int FRAC = itc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [itc_pkg::VEC_W-1:0]  v [3],
	output logic signed [FRAC+2:0]            u [3]
);

	localparam int VW = itc_pkg::VEC_W;
	localparam int UW = FRAC + 3;
	localparam int DIVW = FRAC + 32;
	localparam int SQ_STEPS = 31;

	logic [VW-1:0]        ab_s1 [3];
	logic                 sg_s1 [3];
	logic [2*VW-1:0]      sq_s1 [3];
	logic [61:0]          sx_s [SQ_STEPS+1];
	logic [62:0]          sr_s [SQ_STEPS+1];
	logic [3*VW+2:0]      car_in, car_out;
	logic [DIVW-1:0]      rem_s [3][FRAC+2];
	logic [FRAC:0]        q_s [3][FRAC+2];
	logic [VW-1:0]        dn_s [FRAC+2];
	logic [2:0]           sg_s [FRAC+2];
	logic [VW-1:0]        n_w;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ab_s1[i] <= v[i][VW-1] ? VW'(-v[i]) : VW'(v[i]);
			sg_s1[i] <= v[i][VW-1];
		end
		sq_s1[0] <= ab_s1[0] * ab_s1[0];
		sq_s1[1] <= ab_s1[1] * ab_s1[1];
		sq_s1[2] <= ab_s1[2] * ab_s1[2];
		sx_s[0] <= 62'(sq_s1[0]) + 62'(sq_s1[1]) + 62'(sq_s1[2]);
		sr_s[0] <= '0;
	end

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (2 * (SQ_STEPS - 1 - g));
		always_ff @(posedge clk) begin
			if ({1'b0, sx_s[g]} >= sr_s[g] + BIT) begin
				sx_s[g+1] <= sx_s[g] - 62'(sr_s[g] + BIT);
				sr_s[g+1] <= (sr_s[g] >> 1) + BIT;
			end else begin
				sx_s[g+1] <= sx_s[g];
				sr_s[g+1] <= sr_s[g] >> 1;
			end
		end
	end

	assign car_in = {sg_s1[0], sg_s1[1], sg_s1[2], ab_s1[0], ab_s1[1], ab_s1[2]};

	itc_delay #(.WIDTH(3*VW+3), .DEPTH(SQ_STEPS+2)) u_carry (
		.clk(clk), .arst_n(arst_n), .din(car_in), .dout(car_out)
	);

	assign n_w = VW'(sr_s[SQ_STEPS]);

	always_ff @(posedge clk) begin
		rem_s[0][0] <= (DIVW'(car_out[3*VW-1:2*VW]) << FRAC) + DIVW'(n_w >> 1);
		rem_s[1][0] <= (DIVW'(car_out[2*VW-1:VW]) << FRAC) + DIVW'(n_w >> 1);
		rem_s[2][0] <= (DIVW'(car_out[VW-1:0]) << FRAC) + DIVW'(n_w >> 1);
		for (int i = 0; i < 3; i++) q_s[i][0] <= '0;
		dn_s[0] <= n_w;
		sg_s[0] <= car_out[3*VW+2:3*VW];
	end

	for (genvar g = 0; g <= FRAC; g++) begin : g_div
		localparam int J = FRAC - g;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			always_ff @(posedge clk) begin
				if (rem_s[i][g] >= (DIVW'(dn_s[g]) << J)) begin
					rem_s[i][g+1] <= rem_s[i][g] - (DIVW'(dn_s[g]) << J);
					q_s[i][g+1] <= q_s[i][g] | ((FRAC+1)'(1) << J);
				end else begin
					rem_s[i][g+1] <= rem_s[i][g];
					q_s[i][g+1] <= q_s[i][g];
				end
			end
		end
		always_ff @(posedge clk) begin
			dn_s[g+1] <= dn_s[g];
			sg_s[g+1] <= sg_s[g];
		end
	end

	always_ff @(posedge clk) begin
		u[0] <= sg_s[FRAC+1][2] ? -signed'(UW'(q_s[0][FRAC+1])) : signed'(UW'(q_s[0][FRAC+1]));
		u[1] <= sg_s[FRAC+1][1] ? -signed'(UW'(q_s[1][FRAC+1])) : signed'(UW'(q_s[1][FRAC+1]));
		u[2] <= sg_s[FRAC+1][0] ? -signed'(UW'(q_s[2][FRAC+1])) : signed'(UW'(q_s[2][FRAC+1]));
	end

endmodule

// File: rtl/itc_frame.sv
// Local frame builder: differences, block scaling, cross products and unit axes.
module itc_frame #(
	parameter int FRAC = itc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [itc_pkg::COORD_W-1:0]  a [3],
	input  logic signed [itc_pkg::COORD_W-1:0]  b [3],
	input  logic signed [itc_pkg::COORD_W-1:0]  c [3],
	output logic signed [FRAC+2:0]              ux [3],
	output logic signed [FRAC+2:0]              uy [3],
	output logic signed [FRAC+2:0]              uz [3],
	output logic                                degenerate
);

	localparam int VW = itc_pkg::VEC_W;
	localparam int UW = FRAC + 3;
	localparam int LU = itc_pkg::unit_lat(FRAC);
	localparam logic signed [2*UW-1:0] RND_U = (2*UW)'(1) <<< (FRAC - 1);

	logic signed [32:0]   ba_s1 [3];
	logic signed [32:0]   cb_s1 [3];
	logic signed [VW-1:0] bas [3];
	logic signed [VW-1:0] cbs [3];
	logic signed [VW-1:0] cbd [3];
	logic                 cbz, cbz_d, yz;
	logic signed [61:0]   p_s5 [6];
	logic signed [62:0]   yv_s6 [3];
	logic signed [VW-1:0] yvs [3];
	logic [3*VW-1:0]      cb_pk, cb_pk_d;
	logic signed [UW-1:0] uy_w [3];
	logic signed [UW-1:0] uz_w [3];
	logic signed [UW-1:0] uy_p1 [3];
	logic signed [UW-1:0] uz_p1 [3];
	logic signed [2*UW-1:0] xp_p1 [6];
	logic                 deg_w;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ba_s1[i] <= 33'(a[i]) - 33'(b[i]);
			cb_s1[i] <= 33'(b[i]) - 33'(c[i]);
		end
	end

	itc_bscale #(.IN_W(33)) u_bs_ba (.clk(clk), .v(ba_s1), .o(bas), .zero());
	itc_bscale #(.IN_W(33)) u_bs_cb (.clk(clk), .v(cb_s1), .o(cbs), .zero(cbz));

	always_ff @(posedge clk) begin
		p_s5[0] <= bas[1] * cbs[2];
		p_s5[1] <= bas[2] * cbs[1];
		p_s5[2] <= bas[2] * cbs[0];
		p_s5[3] <= bas[0] * cbs[2];
		p_s5[4] <= bas[0] * cbs[1];
		p_s5[5] <= bas[1] * cbs[0];
		yv_s6[0] <= 63'(p_s5[0]) - 63'(p_s5[1]);
		yv_s6[1] <= 63'(p_s5[2]) - 63'(p_s5[3]);
		yv_s6[2] <= 63'(p_s5[4]) - 63'(p_s5[5]);
	end

	itc_bscale #(.IN_W(63)) u_bs_yv (.clk(clk), .v(yv_s6), .o(yvs), .zero(yz));

	itc_delay #(.WIDTH(1), .DEPTH(5)) u_cbz (
		.clk(clk), .arst_n(arst_n), .din(cbz), .dout(cbz_d)
	);

	assign cb_pk = {cbs[0], cbs[1], cbs[2]};

	itc_delay #(.WIDTH(3*VW), .DEPTH(5)) u_cbd (
		.clk(clk), .arst_n(arst_n), .din(cb_pk), .dout(cb_pk_d)
	);

	assign cbd[0] = signed'(cb_pk_d[3*VW-1:2*VW]);
	assign cbd[1] = signed'(cb_pk_d[2*VW-1:VW]);
	assign cbd[2] = signed'(cb_pk_d[VW-1:0]);

	itc_unit3 #(.FRAC(FRAC)) u_unit_y (.clk(clk), .arst_n(arst_n), .v(yvs), .u(uy_w));
	itc_unit3 #(.FRAC(FRAC)) u_unit_z (.clk(clk), .arst_n(arst_n), .v(cbd), .u(uz_w));

	itc_delay #(.WIDTH(1), .DEPTH(LU+2)) u_deg (
		.clk(clk), .arst_n(arst_n), .din(cbz_d | yz), .dout(deg_w)
	);

	always_ff @(posedge clk) begin
		xp_p1[0] <= uz_w[1] * uy_w[2];
		xp_p1[1] <= uz_w[2] * uy_w[1];
		xp_p1[2] <= uz_w[2] * uy_w[0];
		xp_p1[3] <= uz_w[0] * uy_w[2];
		xp_p1[4] <= uz_w[0] * uy_w[1];
		xp_p1[5] <= uz_w[1] * uy_w[0];
		uy_p1 <= uy_w;
		uz_p1 <= uz_w;
		ux[0] <= UW'((xp_p1[0] - xp_p1[1] + RND_U) >>> FRAC);
		ux[1] <= UW'((xp_p1[2] - xp_p1[3] + RND_U) >>> FRAC);
		ux[2] <= UW'((xp_p1[4] - xp_p1[5] + RND_U) >>> FRAC);
		uy <= uy_p1;
		uz <= uz_p1;
	end

	assign degenerate = deg_w;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the internal-to-Cartesian point placer: directed and random placements against a bit-exact predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = itc_pkg::CORDIC_STEPS_DEF;
	localparam int FB = itc_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = itc_pkg::FRAC_BITS_DEF + 51;

	typedef struct {
		logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [23:0] ang;
		logic signed [25:0] tor;
		logic [23:0] len;
	} placement_t;

	typedef struct {
		logic signed [31:0] dx, dy, dz;
		logic degen;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, degenerate;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	logic signed [31:0] c_x = '0, c_y = '0, c_z = '0;
	logic [23:0] bond_angle = '0;
	logic signed [25:0] torsion = '0;
	logic [23:0] bond_length = '0;
	logic signed [31:0] d_x, d_y, d_z;

	placement_t pending_q[$];
	point_t expected_q[$];
	int mismatches = 0;
	bit feed_done = 0;
	bit hold_until_empty = 0;
	int burst_left = 0;
	int gap_left = 0;

	internal_to_cartesian_point dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void normalise_block(ref longint v[3]);
		longint m;
		m = mag(v[0]);
		if (mag(v[1]) > m) m = mag(v[1]);
		if (mag(v[2]) > m) m = mag(v[2]);
		if (m == 0) return;
		while (m >= (64'sd1 <<< 30)) begin
			for (int i = 0; i < 3; i++) v[i] = floor_shift(v[i], 1);
			m = m >>> 1;
		end
		while (m < (64'sd1 <<< 29)) begin
			for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
			m = m * 2;
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void unit_vector(longint v[3], ref longint u[3]);
		longint unsigned sum, n, a;
		longint q;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a = mag(v[i]);
			sum += a * a;
		end
		n = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			a = mag(v[i]);
			q = 0;
			if (n != 0) q = ((a << FB) + n / 2) / n;
			u[i] = v[i] < 0 ? -q : q;
		end
	endfunction

	function automatic void sin_cos_degrees(longint deg, ref longint s, ref longint c);
		longint t, x, y, z, xs, ys;
		bit flip;
		flip = 0;
		t = deg % longint'(itc_pkg::DEG360);
		if (t < 0) t += itc_pkg::DEG360;
		if (t > itc_pkg::DEG180) t -= itc_pkg::DEG360;
		if (t > itc_pkg::DEG90) begin
			t -= itc_pkg::DEG180;
			flip = 1;
		end else if (t < -longint'(itc_pkg::DEG90)) begin
			t += itc_pkg::DEG180;
			flip = 1;
		end
		z = round_shift(t * longint'(itc_pkg::DEG2RAD_Q32), 18);
		x = longint'(itc_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= longint'(itc_pkg::atan_q30(i[4:0]));
			end else begin
				x += ys;
				y -= xs;
				z += longint'(itc_pkg::atan_q30(i[4:0]));
			end
		end
		c = round_shift(x, 30 - FB);
		s = round_shift(y, 30 - FB);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic point_t place_point(placement_t p);
		longint a[3], b[3], c[3], ba[3], cb[3], yv[3], ux[3], uy[3], uz[3];
		longint st, ct, sp, cp, rs, xp, yp, zp, acc, r;
		point_t res;
		a = '{p.ax, p.ay, p.az};
		b = '{p.bx, p.by, p.bz};
		c = '{p.cx, p.cy, p.cz};
		for (int i = 0; i < 3; i++) begin
			ba[i] = a[i] - b[i];
			cb[i] = b[i] - c[i];
		end
		normalise_block(ba);
		normalise_block(cb);
		yv[0] = ba[1] * cb[2] - ba[2] * cb[1];
		yv[1] = ba[2] * cb[0] - ba[0] * cb[2];
		yv[2] = ba[0] * cb[1] - ba[1] * cb[0];
		if ((cb[0] == 0 && cb[1] == 0 && cb[2] == 0) ||
				(yv[0] == 0 && yv[1] == 0 && yv[2] == 0)) begin
			res.dx = p.cx;
			res.dy = p.cy;
			res.dz = p.cz;
			res.degen = 1'b1;
			return res;
		end
		normalise_block(yv);
		unit_vector(yv, uy);
		unit_vector(cb, uz);
		ux[0] = round_shift(uz[1] * uy[2] - uz[2] * uy[1], FB);
		ux[1] = round_shift(uz[2] * uy[0] - uz[0] * uy[2], FB);
		ux[2] = round_shift(uz[0] * uy[1] - uz[1] * uy[0], FB);
		sin_cos_degrees(longint'(p.ang), st, ct);
		sin_cos_degrees(longint'(p.tor), sp, cp);
		r = longint'(p.len);
		rs = round_shift(r * st, FB);
		xp = round_shift(rs * cp, FB);
		yp = round_shift(rs * sp, FB);
		zp = round_shift(r * ct, FB);
		acc = ux[0] * xp + uy[0] * yp + uz[0] * zp;
		res.dx = clamp32(round_shift(acc, FB) + c[0]);
		acc = ux[1] * xp + uy[1] * yp + uz[1] * zp;
		res.dy = clamp32(round_shift(acc, FB) + c[1]);
		acc = ux[2] * xp + uy[2] * yp + uz[2] * zp;
		res.dz = clamp32(round_shift(acc, FB) + c[2]);
		res.degen = 1'b0;
		return res;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
			2: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
			default: return $signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000;
		endcase
	endfunction

	function automatic placement_t rand_placement();
		placement_t p;
		int kind;
		p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
		p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
		p.cx = rand_coord(); p.cy = rand_coord(); p.cz = rand_coord();
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			p.bx = p.cx; p.by = p.cy; p.bz = p.cz;
		end else if (kind == 1) begin
			p.ax = p.bx; p.ay = p.by; p.az = p.bz;
		end else if (kind == 2) begin
			p.ax = p.bx + (p.bx - p.cx);
			p.ay = p.by + (p.by - p.cy);
			p.az = p.bz + (p.bz - p.cz);
		end
		p.ang = $urandom_range(0, 3) == 0 ? 24'($urandom)
			: 24'($urandom_range(0, itc_pkg::DEG180));
		p.tor = $urandom_range(0, 3) == 0 ? 26'($urandom)
			: 26'($signed($urandom_range(0, 2 * itc_pkg::DEG360)) - itc_pkg::DEG360);
		p.len = 24'($urandom);
		return p;
	endfunction

	function automatic placement_t make_point(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, longint cx, longint cy, longint cz,
			longint ang, longint tor, longint len);
		placement_t p;
		p.ax = 32'(ax); p.ay = 32'(ay); p.az = 32'(az);
		p.bx = 32'(bx); p.by = 32'(by); p.bz = 32'(bz);
		p.cx = 32'(cx); p.cy = 32'(cy); p.cz = 32'(cz);
		p.ang = 24'(ang); p.tor = 26'(tor); p.len = 24'(len);
		return p;
	endfunction

	function automatic void add_placement(placement_t p);
		pending_q.insert(pending_q.size(), p);
	endfunction

	initial begin
		longint one;
		longint mx, mn;
		one = 65536;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, itc_pkg::DEG90, 0, one));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, 0, 0, one));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, itc_pkg::DEG180,
			itc_pkg::DEG180, one));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, 11796480, itc_pkg::DEG360,
			24'hFFFFFF));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, 24'hFFFFFF, -itc_pkg::DEG360,
			one));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, 7864320, 26'sh1FFFFFF, one));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, 7864320, -26'sh2000000, one));
		add_placement(make_point(0, one, 0, 0, 0, 0, one, 0, 0, itc_pkg::DEG90,
			-itc_pkg::DEG90, 0));
		add_placement(make_point(one, 2, 3, 5, 5, 5, 5, 5, 5, itc_pkg::DEG90, 0, one));
		add_placement(make_point(5, 5, 5, 5, 5, 5, 9, 9, 9, itc_pkg::DEG90, 0, one));
		add_placement(make_point(3 * one, 0, 0, 2 * one, 0, 0, one, 0, 0, itc_pkg::DEG90, 0,
			one));
		add_placement(make_point(mn, mn, mn, mx, mx, mx, mn, mn, mn, itc_pkg::DEG90, 0, one));
		add_placement(make_point(mx, mn, 0, mn, mx, mx, mx, mx, mn, 7864320, 1234567,
			24'hFFFFFF));
		add_placement(make_point(mx, mx, mx, mn, 0, mx, 0, mn, mx, 24'h800000, 26'sh1000000,
			24'hFFFFFF));
		add_placement(make_point(mx, mx, mx, mx, mx, 0, mx, mx, mx, itc_pkg::DEG90, 0,
			24'hFFFFFF));
		add_placement(make_point(mn, mn, mn, mn, 0, mn, mn, mn, mn, itc_pkg::DEG90,
			itc_pkg::DEG180, 24'hFFFFFF));
		add_placement(make_point(0, 0, one, 1, 0, 0, 0, 0, 0, 1, -1, 1));
		repeat (400) add_placement(rand_placement());
		feed_done = 1;
	end

	// Driver: one transaction is offered per falling edge, paced by bursts and gaps and by one pause until all results return.
	always @(negedge clk) begin
		placement_t p;
		bit offer;
		offer = 0;
		if (arst_n && !(start && busy)) begin
			if (hold_until_empty) begin
				if (expected_q.size() == 0) hold_until_empty <= 0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_q.size() > 0) begin
				offer = 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
				if (pending_q.size() == 200) hold_until_empty <= 1;
			end
		end
		if (offer) begin
			p = pending_q.pop_front();
			start <= 1'b1;
			a_x <= p.ax; a_y <= p.ay; a_z <= p.az;
			b_x <= p.bx; b_y <= p.by; b_z <= p.bz;
			c_x <= p.cx; c_y <= p.cy; c_z <= p.cz;
			bond_angle <= p.ang;
			torsion <= p.tor;
			bond_length <= p.len;
		end else if (arst_n && start && !busy) begin
			start <= 1'b0;
		end
	end

	// Monitor: predicts on each accepted transaction and checks each strobed result.
	always @(posedge clk) begin
		placement_t p;
		point_t want;
		if (arst_n) begin
			if (start && !busy) begin
				p.ax = a_x; p.ay = a_y; p.az = a_z;
				p.bx = b_x; p.by = b_y; p.bz = b_z;
				p.cx = c_x; p.cy = c_y; p.cz = c_z;
				p.ang = bond_angle; p.tor = torsion; p.len = bond_length;
				expected_q.insert(expected_q.size(), place_point(p));
			end
			if (done) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected result %h %h %h %b", d_x, d_y, d_z,
						degenerate);
				end else begin
					want = expected_q.pop_front();
					if (d_x !== want.dx || d_y !== want.dy || d_z !== want.dz ||
							degenerate !== want.degen) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
								want.dx, want.dy, want.dz, want.degen, d_x, d_y, d_z, degenerate);
					end
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (feed_done && pending_q.size() == 0);
		@(posedge clk);
		while (start) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
